// ----- hw/rtl/backslash_escape_decoder_core_assert.svh -----
// Assertion macros for the backslash escape decoder.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef BACKSLASH_ESCAPE_DECODER_CORE_ASSERT_SVH
`define BACKSLASH_ESCAPE_DECODER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BED_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("backslash escape decoder check failed");

// next-cycle implication, checked out of reset
`define BED_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("backslash escape decoder check failed");

`endif

// ----- hw/rtl/bed_pkg.sv -----
// Shared types and constants for the backslash escape decoder.
// No dependencies; imported by every module and the testbench.
`default_nettype none

package bed_pkg;

    // decoder mode
    typedef enum logic [2:0] {
        MODE_NORMAL    = 3'd0,
        MODE_BACKSLASH = 3'd1,
        MODE_OCT1      = 3'd2,
        MODE_OCT2      = 3'd3,
        MODE_HALTED    = 3'd4
    } t_mode;

    // operation codes of an input request
    localparam logic [1:0] OP_CHAR  = 2'd0;
    localparam logic [1:0] OP_BREAK = 2'd1;
    localparam logic [1:0] OP_EOL   = 2'd2;

    // configuration register indexes
    localparam logic CFG_ESCAPES_ENABLED  = 1'b0;
    localparam logic CFG_SUPPRESS_NEWLINE = 1'b1;

    // character constants
    localparam logic [7:0] CH_BEL       = 8'h07;
    localparam logic [7:0] CH_BS        = 8'h08;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_NL        = 8'h0A;
    localparam logic [7:0] CH_VT        = 8'h0B;
    localparam logic [7:0] CH_FF        = 8'h0C;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_SEVEN     = 8'h37;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_LC_A      = 8'h61;
    localparam logic [7:0] CH_LC_B      = 8'h62;
    localparam logic [7:0] CH_LC_C      = 8'h63;
    localparam logic [7:0] CH_LC_F      = 8'h66;
    localparam logic [7:0] CH_LC_N      = 8'h6E;
    localparam logic [7:0] CH_LC_R      = 8'h72;
    localparam logic [7:0] CH_LC_T      = 8'h74;
    localparam logic [7:0] CH_LC_V      = 8'h76;

    // output buffer geometry
    localparam int OBUF_DEPTH = 4;
    localparam int OBUF_PTR_W = $clog2(OBUF_DEPTH);
    localparam int OBUF_CNT_W = $clog2(OBUF_DEPTH + 1);

    typedef struct packed {
        logic escapes_enabled;
        logic suppress_newline;
    } t_cfg;

    typedef struct packed {
        t_mode      mode;
        logic [7:0] acc;
    } t_dec_state;

    // results of one input request: up to two bytes
    typedef struct packed {
        logic [1:0] num;
        logic [7:0] byte0;
        logic [7:0] byte1;
    } t_dec_result;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_obuf_entry;

    typedef struct packed {
        logic [OBUF_CNT_W-1:0] count;
        logic                  room_for_two;
    } t_obuf_status;

endpackage

`default_nettype wire

// ----- hw/rtl/bed_decode.sv -----
// Combinational decode of one input request: next mode, octal value and results.
// Depends on bed_pkg.
`default_nettype none

module bed_decode
    import bed_pkg::*;
(
    input  wire t_dec_state  i_state,
    input  wire t_cfg        i_cfg,
    input  wire [1:0]        i_operation,
    input  wire [7:0]        i_char_byte,
    output t_dec_state       o_next,
    output t_dec_result      o_result
);

    // {hit, code} for the single-letter escapes and the double backslash
    function automatic logic [8:0] esc_code(input logic [7:0] c);
        logic [8:0] r;
        r = 9'd0;
        unique case (c)
            CH_LC_A:      r = {1'b1, CH_BEL};
            CH_LC_B:      r = {1'b1, CH_BS};
            CH_LC_F:      r = {1'b1, CH_FF};
            CH_LC_N:      r = {1'b1, CH_NL};
            CH_LC_R:      r = {1'b1, CH_CR};
            CH_LC_T:      r = {1'b1, CH_TAB};
            CH_LC_V:      r = {1'b1, CH_VT};
            CH_BACKSLASH: r = {1'b1, CH_BACKSLASH};
            default:      r = 9'd0;
        endcase
        return r;
    endfunction

    logic       is_oct;
    logic       starts_esc;
    logic [8:0] esc;
    logic [7:0] oct_val;
    logic       pending;
    logic [7:0] pend_byte;

    assign is_oct     = (i_char_byte >= CH_ZERO) && (i_char_byte <= CH_SEVEN);
    assign starts_esc = (i_char_byte == CH_BACKSLASH) && i_cfg.escapes_enabled;
    assign esc        = esc_code(i_char_byte);
    assign oct_val    = {i_state.acc[4:0], i_char_byte[2:0]};

    always_comb begin
        pending   = 1'b0;
        pend_byte = i_state.acc;
        unique case (i_state.mode)
            MODE_BACKSLASH: begin
                pending   = 1'b1;
                pend_byte = CH_BACKSLASH;
            end
            MODE_OCT1, MODE_OCT2: begin
                pending = 1'b1;
            end
            default: pending = 1'b0;
        endcase
    end

    always_comb begin
        o_next         = i_state;
        o_result.num   = 2'd0;
        o_result.byte0 = pend_byte;
        o_result.byte1 = i_char_byte;

        unique case (i_operation)
            OP_CHAR: begin
                unique case (i_state.mode)
                    MODE_HALTED: begin
                        // drop everything until end of line
                    end
                    MODE_BACKSLASH: begin
                        priority if (esc[8]) begin
                            o_next.mode    = MODE_NORMAL;
                            o_result.num   = 2'd1;
                            o_result.byte0 = esc[7:0];
                        end else if (i_char_byte == CH_LC_C) begin
                            o_next.mode = MODE_HALTED;
                        end else if (is_oct) begin
                            o_next.acc  = {5'd0, i_char_byte[2:0]};
                            o_next.mode = MODE_OCT1;
                        end else begin
                            // unknown escape: backslash, then the byte
                            o_next.mode    = MODE_NORMAL;
                            o_result.num   = 2'd2;
                            o_result.byte0 = CH_BACKSLASH;
                        end
                    end
                    MODE_OCT1, MODE_OCT2: begin
                        if (is_oct) begin
                            if (i_state.mode == MODE_OCT1) begin
                                o_next.acc  = oct_val;
                                o_next.mode = MODE_OCT2;
                            end else begin
                                o_next.acc     = 8'd0;
                                o_next.mode    = MODE_NORMAL;
                                o_result.num   = 2'd1;
                                o_result.byte0 = oct_val;
                            end
                        end else begin
                            // emit the value, then treat the byte as in normal mode
                            o_next.acc     = 8'd0;
                            o_result.byte0 = i_state.acc;
                            if (starts_esc) begin
                                o_next.mode  = MODE_BACKSLASH;
                                o_result.num = 2'd1;
                            end else begin
                                o_next.mode  = MODE_NORMAL;
                                o_result.num = 2'd2;
                            end
                        end
                    end
                    default: begin
                        if (starts_esc) begin
                            o_next.mode = MODE_BACKSLASH;
                        end else begin
                            o_next.mode    = MODE_NORMAL;
                            o_result.num   = 2'd1;
                            o_result.byte0 = i_char_byte;
                        end
                    end
                endcase
            end
            OP_BREAK: begin
                if (i_state.mode != MODE_HALTED) begin
                    o_next.mode    = MODE_NORMAL;
                    o_next.acc     = 8'd0;
                    o_result.byte1 = CH_SPACE;
                    if (pending) begin
                        o_result.num = 2'd2;
                    end else begin
                        o_result.num   = 2'd1;
                        o_result.byte0 = CH_SPACE;
                    end
                end
            end
            OP_EOL: begin
                o_next.mode    = MODE_NORMAL;
                o_next.acc     = 8'd0;
                o_result.byte1 = CH_NL;
                if (i_state.mode != MODE_HALTED) begin
                    unique case ({pending, i_cfg.suppress_newline})
                        2'b10: o_result.num = 2'd2;
                        2'b11: o_result.num = 2'd1;
                        2'b00: begin
                            o_result.num   = 2'd1;
                            o_result.byte0 = CH_NL;
                        end
                        default: o_result.num = 2'd0;
                    endcase
                end
            end
            default: begin
                // unused operation code: no result, state held
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/bed_obuf.sv -----
// Output result buffer: takes up to two entries per cycle, gives one per cycle
// unless stalled. Depends on bed_pkg.
`default_nettype none

module bed_obuf
    import bed_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire [1:0]         i_wr_num,
    input  wire t_obuf_entry  i_wr0,
    input  wire t_obuf_entry  i_wr1,
    output logic              o_valid,
    input  wire               i_stall,
    output t_obuf_entry       o_entry,
    output t_obuf_status      o_status
);

    t_obuf_entry           r_mem [OBUF_DEPTH];
    logic [OBUF_PTR_W-1:0] r_wr;
    logic [OBUF_PTR_W-1:0] r_rd;
    logic [OBUF_CNT_W-1:0] r_count;
    logic [OBUF_PTR_W-1:0] n_wr;
    logic [OBUF_PTR_W-1:0] n_rd;
    logic [OBUF_CNT_W-1:0] n_count;
    logic [OBUF_PTR_W-1:0] wr_next_slot;
    logic                  rd_en;

    assign o_valid      = (r_count != '0);
    assign o_entry      = r_mem[r_rd];
    assign rd_en        = o_valid && !i_stall;
    assign wr_next_slot = r_wr + OBUF_PTR_W'(1);

    assign o_status.count        = r_count;
    assign o_status.room_for_two = (r_count <= OBUF_CNT_W'(OBUF_DEPTH - 2));

    always_comb begin
        n_wr    = r_wr + OBUF_PTR_W'(i_wr_num);
        n_rd    = r_rd + OBUF_PTR_W'(rd_en);
        n_count = r_count + OBUF_CNT_W'(i_wr_num) - OBUF_CNT_W'(rd_en);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_num != 2'd0) begin
            r_mem[r_wr] <= i_wr0;
        end
        if (i_wr_num == 2'd2) begin
            r_mem[wr_next_slot] <= i_wr1;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/backslash_escape_decoder_core.sv -----
// Backslash escape decoder: top level with configuration, decode state and output buffer.
// Depends on bed_pkg, bed_decode, bed_obuf and backslash_escape_decoder_core_assert.svh.
`default_nettype none

`include "backslash_escape_decoder_core_assert.svh"

// Decodes a stream of argument characters, argument breaks and end-of-line markers
// into output bytes, one input request per clock cycle unless the input stalls. The
// decode mode and octal value are updated in the cycle a request is taken, and its
// zero, one or two result bytes go straight into a four-entry output buffer whose
// head drives the result port. The input side stalls only when that buffer has
// fewer than two free entries, so requests that give at most one result flow at one
// per cycle while the output is not stalled; requests that give two results (unknown
// escape, octal value ended by a byte other than an escape-starting backslash,
// pending escape before a space or an unsuppressed newline) put two bytes on the
// output port, which at one result per cycle sets the sustained rate. Configuration
// writes are always ready and take effect from the next request.
module backslash_escape_decoder_core
    import bed_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire        i_cfg_index,
    input  wire        i_cfg_data,
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  wire [1:0]  i_operation,
    input  wire [7:0]  i_char_byte,
    output logic       o_out_valid,
    input  wire        i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run
);

    t_cfg         r_cfg;
    t_dec_state   r_state;
    t_dec_state   n_state;
    t_dec_result  dec_res;
    t_obuf_entry  wr0;
    t_obuf_entry  wr1;
    t_obuf_entry  head;
    t_obuf_status obuf_st;
    logic         in_acc;
    logic [1:0]   wr_num;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = !obuf_st.room_for_two;
    assign in_acc      = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_ESCAPES_ENABLED:  r_cfg.escapes_enabled  <= i_cfg_data;
                CFG_SUPPRESS_NEWLINE: r_cfg.suppress_newline <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bed_decode u_decode (
        .i_state     (r_state),
        .i_cfg       (r_cfg),
        .i_operation (i_operation),
        .i_char_byte (i_char_byte),
        .o_next      (n_state),
        .o_result    (dec_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode <= MODE_NORMAL;
            r_state.acc  <= 8'd0;
        end else if (in_acc) begin
            r_state <= n_state;
        end
    end

    // the last result of a request carries the run marker
    assign wr_num           = in_acc ? dec_res.num : 2'd0;
    assign wr0.out_byte     = dec_res.byte0;
    assign wr0.last_of_run  = (dec_res.num == 2'd1);
    assign wr1.out_byte     = dec_res.byte1;
    assign wr1.last_of_run  = 1'b1;

    bed_obuf u_obuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_num (wr_num),
        .i_wr0    (wr0),
        .i_wr1    (wr1),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_entry  (head),
        .o_status (obuf_st)
    );

    assign o_out_byte    = head.out_byte;
    assign o_last_of_run = head.last_of_run;

    `BED_ASSERT_IMP(a_halted_silent,
        in_acc && (r_state.mode == MODE_HALTED) && (i_operation != OP_EOL),
        (wr_num == 2'd0) && (n_state == r_state))
    `BED_ASSERT_NXT(a_eol_resets,
        in_acc && (i_operation == OP_EOL),
        (r_state.mode == MODE_NORMAL) && (r_state.acc == 8'd0))
    `BED_ASSERT_IMP(a_break_space,
        in_acc && (i_operation == OP_BREAK) && (r_state.mode != MODE_HALTED),
        ((wr_num == 2'd1) && (dec_res.byte0 == CH_SPACE)) ||
        ((wr_num == 2'd2) && (dec_res.byte1 == CH_SPACE)))
    `BED_ASSERT_NXT(a_buffer_fill,
        in_acc && (wr_num == 2'd2) && !o_out_valid,
        o_out_valid && (obuf_st.count == OBUF_CNT_W'(2)))

endmodule

`default_nettype wire

// ----- dv/bed_result_checker.sv -----
// Result checker for the backslash escape decoder: watches the configuration, request and
// result channels, predicts each request's output bytes and compares them in order.
// Depends on bed_pkg for the mode, operation, register index and character constants.
module bed_result_checker
    import bed_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_valid,
    input  wire        i_cfg_ready,
    input  wire        i_cfg_index,
    input  wire        i_cfg_data,
    input  wire        i_in_valid,
    input  wire        i_in_stall,
    input  wire [1:0]  i_operation,
    input  wire [7:0]  i_char_byte,
    input  wire        i_out_valid,
    input  wire        i_out_stall,
    input  wire [7:0]  i_out_byte,
    input  wire        i_last_of_run,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_checked
);

    // predicted decoder state and register copies
    t_mode       esc_mode;
    logic [7:0]  octal_val;
    logic        esc_on;
    logic        nl_off;

    // bytes produced by the request being predicted
    logic [7:0]  run_bytes [2];
    int          run_len;

    t_obuf_entry expected_bytes [$];
    int          errors;
    int          checked;

    assign o_fail_count = errors;
    assign o_checked    = checked;

    initial begin
        errors  = 0;
        checked = 0;
    end

    function automatic logic is_octal(input logic [7:0] ch);
        return ch >= CH_ZERO && ch <= CH_SEVEN;
    endfunction

    function automatic void emit(input logic [7:0] b);
        run_bytes[run_len] = b;
        run_len++;
    endfunction

    function automatic void plain_char(input logic [7:0] ch);
        if (ch == CH_BACKSLASH && esc_on) begin
            esc_mode = MODE_BACKSLASH;
        end else begin
            esc_mode = MODE_NORMAL;
            emit(ch);
        end
    endfunction

    // a marker ends any escape in progress: give back what it holds
    function automatic void flush_escape();
        if (esc_mode == MODE_BACKSLASH) begin
            emit(CH_BACKSLASH);
        end else if (esc_mode == MODE_OCT1 || esc_mode == MODE_OCT2) begin
            emit(octal_val);
        end
        esc_mode  = MODE_NORMAL;
        octal_val = '0;
    endfunction

    function automatic void after_backslash(input logic [7:0] ch);
        esc_mode = MODE_NORMAL;
        case (ch)
            CH_LC_A:      emit(CH_BEL);
            CH_LC_B:      emit(CH_BS);
            CH_LC_F:      emit(CH_FF);
            CH_LC_N:      emit(CH_NL);
            CH_LC_R:      emit(CH_CR);
            CH_LC_T:      emit(CH_TAB);
            CH_LC_V:      emit(CH_VT);
            CH_BACKSLASH: emit(CH_BACKSLASH);
            CH_LC_C:      esc_mode = MODE_HALTED;
            default: begin
                if (is_octal(ch)) begin
                    octal_val = {5'd0, ch[2:0]};
                    esc_mode  = MODE_OCT1;
                end else begin
                    emit(CH_BACKSLASH);
                    emit(ch);
                end
            end
        endcase
    endfunction

    function automatic void decode_request(input logic [1:0] op, input logic [7:0] ch);
        logic [7:0] v;
        run_len = 0;
        case (op)
            OP_CHAR: begin
                case (esc_mode)
                    MODE_HALTED: begin
                        // drop everything until end of line
                    end
                    MODE_BACKSLASH: after_backslash(ch);
                    MODE_OCT1, MODE_OCT2: begin
                        if (is_octal(ch)) begin
                            v = {octal_val[4:0], ch[2:0]};
                            if (esc_mode == MODE_OCT1) begin
                                octal_val = v;
                                esc_mode  = MODE_OCT2;
                            end else begin
                                emit(v);
                                octal_val = '0;
                                esc_mode  = MODE_NORMAL;
                            end
                        end else begin
                            emit(octal_val);
                            octal_val = '0;
                            plain_char(ch);
                        end
                    end
                    default: plain_char(ch);
                endcase
            end
            OP_BREAK: begin
                if (esc_mode != MODE_HALTED) begin
                    flush_escape();
                    emit(CH_SPACE);
                end
            end
            OP_EOL: begin
                if (esc_mode != MODE_HALTED) begin
                    flush_escape();
                    if (!nl_off) begin
                        emit(CH_NL);
                    end
                end
                esc_mode  = MODE_NORMAL;
                octal_val = '0;
            end
            default: begin
                // unused operation code: no output, state held
            end
        endcase
        for (int k = 0; k < run_len; k++) begin
            expected_bytes.push_back(t_obuf_entry'{run_bytes[k], k == run_len - 1});
        end
    endfunction

    always @(posedge i_clk) begin
        t_obuf_entry want;
        if (!i_rst_n) begin
            esc_mode  = MODE_NORMAL;
            octal_val = '0;
            esc_on    = 1'b0;
            nl_off    = 1'b0;
            expected_bytes.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_ESCAPES_ENABLED) begin
                    esc_on = i_cfg_data;
                end else begin
                    nl_off = i_cfg_data;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                decode_request(i_operation, i_char_byte);
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_bytes.size() == 0) begin
                    errors++;
                    $display("%0t: expected no result, got byte %02h last %0b",
                             $time, i_out_byte, i_last_of_run);
                end else begin
                    want = expected_bytes.pop_front();
                    checked++;
                    if (want.out_byte !== i_out_byte || want.last_of_run !== i_last_of_run) begin
                        errors++;
                        $display("%0t: expected byte %02h last %0b, got byte %02h last %0b",
                                 $time, want.out_byte, want.last_of_run,
                                 i_out_byte, i_last_of_run);
                    end
                end
            end
        end
        o_pending <= expected_bytes.size();
    end

endmodule

// ----- dv/backslash_escape_decoder_core_test.sv -----
// Testbench top for the backslash escape decoder: clock, reset, request and configuration
// stimulus, output stalls and the verdict. Depends on bed_pkg, bed_result_checker and
// backslash_escape_decoder_core.
module backslash_escape_decoder_core_test;
    import bed_pkg::*;

    // operation code with no meaning; the block ignores it
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam int ITEM_GOAL   = 1800;
    localparam int HOLD_CYCLES = 64;

    localparam logic [7:0] ESC_LETTERS [8] = '{CH_LC_A, CH_LC_B, CH_LC_F, CH_LC_N,
                                               CH_LC_R, CH_LC_T, CH_LC_V, CH_BACKSLASH};

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_index = CFG_ESCAPES_ENABLED;
    logic       cfg_data  = 1'b0;
    logic       in_valid  = 1'b0;
    logic [1:0] operation = OP_CHAR;
    logic [7:0] char_byte = 8'h00;
    logic       out_stall = 1'b0;

    wire        cfg_ready;
    wire        in_stall;
    wire        out_valid;
    wire [7:0]  out_byte;
    wire        last_of_run;

    int fail_count;
    int pending;
    int checked;

    int   items_sent   = 0;
    int   phases       = 0;
    logic in_gaps      = 1'b0;
    logic out_gaps     = 1'b0;
    logic hold_out_req = 1'b0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    backslash_escape_decoder_core u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_operation   (operation),
        .i_char_byte   (char_byte),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out_byte    (out_byte),
        .o_last_of_run (last_of_run)
    );

    bed_result_checker u_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_operation   (operation),
        .i_char_byte   (char_byte),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_byte    (out_byte),
        .i_last_of_run (last_of_run),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    // Offer one request and hold it until taken; valid stays high for the next one.
    task automatic send_item(input logic [1:0] op, input logic [7:0] ch);
        if (in_gaps && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        char_byte <= ch;
        do @(posedge clk); while (in_stall);
        if (op != OP_NONE) begin
            items_sent++;
        end
    endtask

    // Stop offering and wait until every predicted byte has come out.
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        // a request with no output may still be in flight
        repeat (4) @(posedge clk);
    endtask

    task automatic write_config(input logic esc, input logic nl);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_ESCAPES_ENABLED;
        cfg_data  <= esc;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= CFG_SUPPRESS_NEWLINE;
        cfg_data  <= nl;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        phases++;
    endtask

    task automatic send_backslash();
        send_item(OP_CHAR, CH_BACKSLASH);
    endtask

    // One random piece of text: a well-formed escape, a noise byte or escape, or a marker.
    task automatic send_token();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            send_item(OP_CHAR, 8'($urandom));
        end else if (pick < 45) begin
            send_backslash();
            send_item(OP_CHAR, ESC_LETTERS[$urandom_range(0, 7)]);
        end else if (pick < 62) begin
            send_backslash();
            repeat ($urandom_range(1, 3)) send_item(OP_CHAR, CH_ZERO | 8'($urandom_range(0, 7)));
        end else if (pick < 67) begin
            send_backslash();
            send_item(OP_CHAR, CH_LC_C);
        end else if (pick < 75) begin
            send_backslash();
            send_item(OP_CHAR, 8'($urandom));
        end else if (pick < 87) begin
            send_item(OP_BREAK, 8'($urandom));
        end else if (pick < 97) begin
            send_item(OP_EOL, 8'($urandom));
        end else begin
            send_item(OP_NONE, 8'($urandom));
        end
    endtask

    // Output side: random stall bursts, or one long hold when asked.
    initial begin
        forever begin
            @(posedge clk);
            if (hold_out_req) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                hold_out_req = 1'b0;
            end else if (out_gaps && $urandom_range(0, 7) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial begin
        #4_000_000;
        $display("run timed out with %0d bytes outstanding", pending);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int wait_cycles;
        int tokens;
        logic last_stretch;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        in_gaps  = 1'b1;
        out_gaps = 1'b1;

        // escapes off: bytes pass unchanged, backslash included
        write_config(1'b0, 1'b0);
        send_item(OP_CHAR, 8'hFF);
        send_backslash();
        send_item(OP_BREAK, 8'hFF);
        send_item(OP_NONE, 8'h5A);
        send_item(OP_EOL, 8'h00);
        settle();

        write_config(1'b1, 1'b0);
        // unknown escape gives backslash then the byte
        send_backslash();
        send_item(OP_CHAR, 8'h71);
        // three digits emit at once; 777 wraps
        send_backslash();
        repeat (3) send_item(OP_CHAR, CH_SEVEN);
        // octal cut short by a backslash that starts a new escape
        send_backslash();
        send_item(OP_CHAR, 8'h35);
        send_backslash();
        send_item(OP_CHAR, CH_LC_N);
        // lone backslash flushed ahead of the space
        send_backslash();
        send_item(OP_BREAK, 8'h00);
        // halt swallows bytes, the break and the newline
        send_backslash();
        send_item(OP_CHAR, CH_LC_C);
        send_item(OP_CHAR, 8'h7A);
        send_item(OP_BREAK, 8'h00);
        send_item(OP_EOL, 8'h00);
        // escape begun before escapes are switched off still completes
        send_backslash();
        settle();
        write_config(1'b0, 1'b1);
        send_item(OP_CHAR, 8'h31);
        send_item(OP_CHAR, 8'h32);
        send_item(OP_EOL, 8'hFF);

        while (items_sent < ITEM_GOAL) begin
            settle();
            write_config($urandom_range(0, 1), $urandom_range(0, 1));
            last_stretch = items_sent >= ITEM_GOAL - 250;
            in_gaps  = !last_stretch && $urandom_range(0, 3) != 0;
            out_gaps = !last_stretch && $urandom_range(0, 3) != 0;
            if (phases == 4) begin
                // hold the output long enough for the block to back up its input
                in_gaps = 1'b0;
                hold_out_req = 1'b1;
                repeat (40) send_item(OP_CHAR, 8'($urandom));
            end
            tokens = $urandom_range(60, 200);
            while (tokens > 0 && items_sent < ITEM_GOAL) begin
                // no idling once the run nears its end
                if (items_sent >= ITEM_GOAL - 250) begin
                    last_stretch = 1'b1;
                    in_gaps      = 1'b0;
                    out_gaps     = 1'b0;
                end
                send_token();
                if (!last_stretch && $urandom_range(0, 99) == 0) begin
                    settle();
                end
                tokens--;
            end
        end

        in_valid <= 1'b0;
        wait_cycles = 0;
        do begin
            @(posedge clk);
            wait_cycles++;
        end while (pending != 0 && wait_cycles < 5000);
        repeat (8) @(posedge clk);

        if (pending != 0) begin
            $display("%0d predicted bytes never came out", pending);
        end
        $display("Sent %0d requests over %0d register settings; %0d output bytes compared.",
                 items_sent, phases, checked);
        $display("Included escapes, octal runs, halts, markers, long output hold and stalls.");
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
